// ===== sv/x224_connection_request_handler_core_macros.svh =====
// Assertion helpers for the connection request handler.
// Each one samples on the block clock and is held off while reset is low.
`ifndef X224_CONNECTION_REQUEST_HANDLER_CORE_MACROS_SVH
`define X224_CONNECTION_REQUEST_HANDLER_CORE_MACROS_SVH

// Same-cycle implication.
`define X224CRH_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define X224CRH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/x224crh_pkg.sv =====
package x224crh_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SECURITY_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VM_CONNECT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TLS_READY     = 2'd2;

    localparam logic [1:0] SEC_RDP_ONLY = 2'd0;
    localparam logic [1:0] SEC_TLS_REQ  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NEG_FAIL  = 3'd1;
    localparam logic [2:0] ST_BAD_HDR   = 3'd2;
    localparam logic [2:0] ST_NOT_CR    = 3'd3;
    localparam logic [2:0] ST_LI_MISM   = 3'd4;
    localparam logic [2:0] ST_BAD_NEG   = 3'd5;
    localparam logic [2:0] ST_TRUNC     = 3'd6;

    localparam logic [3:0] PROTO_RDP    = 4'd0;
    localparam logic [3:0] PROTO_TLS    = 4'd1;
    localparam logic [3:0] PROTO_HYBRID = 4'd2;
    localparam logic [3:0] PROTO_HYB_EX = 4'd8;

    localparam logic [1:0] FAIL_NONE     = 2'd0;
    localparam logic [1:0] FAIL_SSL_REQ  = 2'd1;
    localparam logic [1:0] FAIL_NO_CERT  = 2'd3;

    localparam logic [7:0] TPKT_VERSION  = 8'h03;
    localparam logic [7:0] TPDU_CR       = 8'hE0;
    localparam logic [7:0] TPDU_CC       = 8'hD0;
    localparam logic [7:0] TPDU_DT       = 8'hF0;
    localparam logic [7:0] LI_INVALID    = 8'hFF;
    localparam logic [7:0] OPT_NEG_REQ   = 8'h01;
    localparam logic [7:0] OPT_NEG_RSP   = 8'h02;
    localparam logic [7:0] OPT_NEG_FAIL  = 8'h03;
    localparam logic [7:0] OPT_CORR_INFO = 8'h06;
    localparam logic [7:0] OPT_COOKIE    = 8'h43;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] NEG_FLAG_MASK = 8'h0B;
    localparam logic [7:0] NEG_REC_LEN   = 8'h08;
    localparam logic [7:0] MAX_PROTOCOLS = 8'h0B;
    localparam logic [7:0] SRC_REF_HI    = 8'h12;
    localparam logic [7:0] SRC_REF_LO    = 8'h34;
    localparam logic [7:0] RSP_FLAGS     = 8'h01;
    localparam logic [7:0] RSP_FLAGS_VM  = 8'h09;

    localparam logic [5:0] NEG_REQ_BYTES = 6'd7;
    localparam logic [5:0] CORR_BYTES    = 6'd35;
    localparam logic [8:0] POS_MAX       = 9'd511;

    localparam logic [4:0] CC_LEN_SHORT  = 5'd11;
    localparam logic [4:0] CC_LEN_LONG   = 5'd19;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_TYPE   = 3'd1,
        PH_NEGREQ = 3'd2,
        PH_CORR   = 3'd3,
        PH_COOKIE = 3'd4,
        PH_STOP   = 3'd5
    } t_phase;

    typedef struct packed {
        logic [1:0] sec_mode;
        logic       vm_mode;
        logic       tls_ready;
    } t_cfg;

    // What the confirm generator needs to know about one finished request.
    typedef struct packed {
        logic [2:0] status;
        logic [3:0] proto;
        logic [1:0] fail;
        logic       neg_seen;
        logic       vm_mode;
    } t_summary;

    function automatic logic [4:0] cc_len(t_summary s);
        return s.neg_seen ? CC_LEN_LONG : CC_LEN_SHORT;
    endfunction

    function automatic logic [7:0] cc_byte(logic [4:0] idx, t_summary s);
        logic [7:0] b;
        logic       f;
        f = (s.fail != FAIL_NONE);
        unique case (idx)
            5'd0:    b = TPKT_VERSION;
            5'd3:    b = {3'd0, cc_len(s)};
            5'd4:    b = {3'd0, cc_len(s)} - 8'd5;
            5'd5:    b = TPDU_CC;
            5'd8:    b = SRC_REF_HI;
            5'd9:    b = SRC_REF_LO;
            5'd11:   b = f ? OPT_NEG_FAIL : OPT_NEG_RSP;
            5'd12:   b = f ? 8'h00 : (s.vm_mode ? RSP_FLAGS_VM : RSP_FLAGS);
            5'd13:   b = NEG_REC_LEN;
            5'd15:   b = f ? {6'd0, s.fail} : {4'd0, s.proto};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/x224crh_in_if.sv =====
interface x224crh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       rx_last;

    modport source (output valid, output rx_byte, output rx_last, input ready);
    modport sink   (input valid, input rx_byte, input rx_last, output ready);
endinterface

// ===== sv/x224crh_out_if.sv =====
interface x224crh_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] response_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic [3:0] selected_protocol;
    logic       end_of_response;

    modport source (output valid, output response_byte, output byte_valid, output status,
                    output selected_protocol, output end_of_response, input ready);
    modport sink   (input valid, input response_byte, input byte_valid, input status,
                    input selected_protocol, input end_of_response, output ready);
endinterface

// ===== sv/x224crh_parser.sv =====
module x224crh_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    input  x224crh_pkg::t_cfg     i_cfg,
    output logic                  o_push,
    output x224crh_pkg::t_summary o_sum
);
    import x224crh_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [8:0]  r_pos,    n_pos;
    logic [5:0]  r_fc,     n_fc;
    logic [7:0]  r_li,     n_li;
    logic [7:0]  r_code,   n_code;
    logic [3:0]  r_req,    n_req;
    logic [7:0]  r_oflags, n_oflags;
    logic [15:0] r_olen,   n_olen;
    logic        r_neg,    n_neg;
    logic        r_cr,     n_cr;
    logic [2:0]  r_err,    n_err;
    logic        r_bad,    n_bad;

    logic [2:0]  st;
    logic [3:0]  mask;
    logic [3:0]  proto;
    logic [1:0]  fail;

    always_comb begin
        n_phase  = r_phase;
        n_fc     = r_fc;
        n_li     = r_li;
        n_code   = r_code;
        n_req    = r_req;
        n_oflags = r_oflags;
        n_olen   = r_olen;
        n_neg    = r_neg;
        n_cr     = r_cr;
        n_err    = r_err;
        n_bad    = r_bad;
        unique case (r_phase)
            PH_HEADER: begin
                if (r_pos == 9'd0 && i_byte != TPKT_VERSION) n_err = ST_BAD_HDR;
                if (r_pos == 9'd4) n_li = i_byte;
                if (r_pos == 9'd5) n_code = i_byte;
                if (r_pos == 9'd10) n_phase = PH_TYPE;
            end
            PH_TYPE: begin
                if (i_byte == OPT_NEG_REQ) begin
                    n_neg   = 1'b1;
                    n_phase = PH_NEGREQ;
                    n_fc    = 6'd0;
                    n_bad   = 1'b0;
                end else if (i_byte == OPT_CORR_INFO) begin
                    n_phase = PH_CORR;
                    n_fc    = 6'd0;
                end else if (i_byte == OPT_COOKIE) begin
                    n_phase = PH_COOKIE;
                    n_cr    = 1'b0;
                end
            end
            PH_NEGREQ: begin
                priority if (r_fc == 6'd0) begin
                    n_oflags = i_byte;
                    if ((i_byte & NEG_FLAG_MASK) != i_byte || (i_byte[1] && !i_byte[0]))
                        n_bad = 1'b1;
                end else if (r_fc == 6'd1) begin
                    n_olen = {8'h00, i_byte};
                end else if (r_fc == 6'd2) begin
                    n_olen = r_olen | {i_byte, 8'h00};
                    if (n_olen != {8'h00, NEG_REC_LEN}) n_bad = 1'b1;
                end else if (r_fc == 6'd3) begin
                    if (i_byte > MAX_PROTOCOLS) n_bad = 1'b1;
                    else                        n_req = i_byte[3:0];
                end else begin
                    if (i_byte != 8'h00) n_bad = 1'b1;
                end
                n_fc = r_fc + 6'd1;
                if (n_fc >= NEG_REQ_BYTES) begin
                    if (n_bad) begin
                        if (r_err == ST_OK) n_err = ST_BAD_NEG;
                        n_phase = PH_STOP;
                    end else begin
                        n_phase = PH_TYPE;
                    end
                end
            end
            PH_CORR: begin
                n_fc = r_fc + 6'd1;
                if (n_fc >= CORR_BYTES) n_phase = PH_TYPE;
            end
            PH_COOKIE: begin
                if (r_cr && i_byte == CHAR_LF) begin
                    n_cr    = 1'b0;
                    n_phase = PH_TYPE;
                end else begin
                    n_cr = (i_byte == CHAR_CR);
                end
            end
            default: ;
        endcase
        n_pos = (r_pos < POS_MAX) ? r_pos + 9'd1 : r_pos;
    end

    // Verdict on the request as it stands after this byte.
    always_comb begin
        priority if (n_pos < 9'd6 || n_err == ST_BAD_HDR || n_li == LI_INVALID)
            st = ST_BAD_HDR;
        else if (n_code == TPDU_DT)
            st = (n_pos < 9'd7) ? ST_BAD_HDR : ST_NOT_CR;
        else if (n_pos < 9'd11)
            st = ST_BAD_HDR;
        else if (n_code != TPDU_CR)
            st = ST_NOT_CR;
        else if ({1'b0, n_li} != n_pos - 9'd5)
            st = ST_LI_MISM;
        else if (n_err != ST_OK)
            st = n_err;
        else if (n_phase == PH_NEGREQ || n_phase == PH_CORR)
            st = ST_TRUNC;
        else
            st = ST_OK;
    end

    // Protocol choice: highest-priority protocol both sides allow.
    always_comb begin
        mask  = (i_cfg.sec_mode == SEC_RDP_ONLY) ? 4'd0 : PROTO_TLS;
        if (i_cfg.vm_mode) mask = mask | PROTO_HYBRID | PROTO_HYB_EX;
        mask  = mask & n_req;
        proto = PROTO_RDP;
        fail  = FAIL_NONE;
        priority if (mask[3]) begin
            proto = PROTO_HYB_EX;
        end else if (mask[1]) begin
            proto = PROTO_HYBRID;
        end else if (mask[0]) begin
            if (i_cfg.tls_ready || i_cfg.vm_mode) proto = PROTO_TLS;
            else if (i_cfg.sec_mode == SEC_TLS_REQ) fail = FAIL_NO_CERT;
        end else if (i_cfg.sec_mode == SEC_TLS_REQ) begin
            fail = FAIL_SSL_REQ;
        end else begin
            fail = FAIL_NONE;
        end
    end

    assign o_push = i_take && i_last;

    always_comb begin
        o_sum.vm_mode  = i_cfg.vm_mode;
        o_sum.neg_seen = n_neg;
        if (st != ST_OK) begin
            o_sum.status = st;
            o_sum.proto  = PROTO_RDP;
            o_sum.fail   = FAIL_NONE;
        end else begin
            o_sum.status = (fail != FAIL_NONE) ? ST_NEG_FAIL : ST_OK;
            o_sum.proto  = proto;
            o_sum.fail   = fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_fc     <= '0;
            r_li     <= '0;
            r_code   <= '0;
            r_req    <= '0;
            r_oflags <= '0;
            r_olen   <= '0;
            r_neg    <= 1'b0;
            r_cr     <= 1'b0;
            r_err    <= ST_OK;
            r_bad    <= 1'b0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_fc     <= n_fc;
            r_li     <= n_li;
            r_code   <= n_code;
            r_req    <= n_req;
            r_oflags <= n_oflags;
            r_olen   <= n_olen;
            r_neg    <= n_neg;
            r_cr     <= n_cr;
            r_err    <= n_err;
            r_bad    <= n_bad;
        end
    end

endmodule

// ===== sv/x224_connection_request_handler_core.sv =====
// X.224 connection request handler. Feed the request PDU one byte per beat on
// i_req, with rx_last on its final byte; the block checks the TPKT and X.224
// headers, walks the option records and, on the final byte, answers on o_rsp
// with either the 11- or 19-beat connection confirm (19 when the request held
// a negotiation record) or a single error beat with byte_valid low. The
// request side takes one byte every cycle: each byte only moves a small parse
// state. The verdict on a finished request is held in a one-entry queue ahead
// of the confirm generator, so the next request streams in while the current
// confirm drains; only a final byte that arrives while one confirm is still
// being sent and another is already queued waits (ready low) until the
// generator picks up the queued one. A verdict is registered in the queue,
// then in the generator, before its first beat shows. Configuration registers
// are plain writes and are meant to change only while the block is idle.
`include "x224_connection_request_handler_core_macros.svh"

module x224_connection_request_handler_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    x224crh_in_if.sink                          i_req,
    x224crh_out_if.source                       o_rsp,
    input  logic                                i_cfg_wr_en,
    input  logic [x224crh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [x224crh_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import x224crh_pkg::*;

    t_cfg       r_cfg;
    logic       take;
    logic       push;
    t_summary   push_sum;

    logic       r_pend_vld;
    t_summary   r_pend_sum;

    logic       r_emit_vld;
    logic [4:0] r_emit_idx;
    t_summary   r_emit_sum;

    logic       out_fire;
    logic       emit_err;
    logic       emit_last;
    logic       pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sec_mode  <= 2'd1;
            r_cfg.vm_mode   <= 1'b0;
            r_cfg.tls_ready <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SECURITY_MODE: r_cfg.sec_mode  <= i_cfg_wdata;
                CFG_VM_CONNECT:    r_cfg.vm_mode   <= i_cfg_wdata[0];
                CFG_TLS_READY:     r_cfg.tls_ready <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Hold only a final byte, and only while the verdict queue is full and
    // not being emptied this cycle; every other byte goes straight in.
    assign i_req.ready = !r_pend_vld || pop || !i_req.rx_last;
    assign take        = i_req.valid && i_req.ready;

    x224crh_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_req.rx_byte),
        .i_last  (i_req.rx_last),
        .i_cfg   (r_cfg),
        .o_push  (push),
        .o_sum   (push_sum)
    );

    // Confirm generator: one beat per cycle while o_rsp.ready is high, out of the held verdict.
    assign out_fire  = o_rsp.valid && o_rsp.ready;
    assign emit_err  = (r_emit_sum.status != ST_OK) && (r_emit_sum.status != ST_NEG_FAIL);
    assign emit_last = emit_err || (r_emit_idx == cc_len(r_emit_sum) - 5'd1);
    assign pop       = r_pend_vld && (!r_emit_vld || (out_fire && emit_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (push) begin
            r_pend_vld <= 1'b1;
        end else if (pop) begin
            r_pend_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_pend_sum <= push_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_vld <= 1'b0;
            r_emit_idx <= '0;
        end else if (pop) begin
            r_emit_vld <= 1'b1;
            r_emit_idx <= '0;
        end else if (out_fire) begin
            // Advance through the confirm; drop valid after its last beat.
            r_emit_vld <= !emit_last;
            r_emit_idx <= r_emit_idx + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) r_emit_sum <= r_pend_sum;
    end

    assign o_rsp.valid             = r_emit_vld;
    assign o_rsp.response_byte     = emit_err ? 8'h00 : cc_byte(r_emit_idx, r_emit_sum);
    assign o_rsp.byte_valid        = !emit_err;
    assign o_rsp.status            = r_emit_sum.status;
    assign o_rsp.selected_protocol = r_emit_sum.proto;
    assign o_rsp.end_of_response   = emit_last;

    `X224CRH_ASSERT_IMPL(a_err_single_beat, o_rsp.valid && !o_rsp.byte_valid, o_rsp.end_of_response, "error beat not marked as last")
    `X224CRH_ASSERT_IMPL(a_idx_in_range, r_emit_vld, r_emit_idx < cc_len(r_emit_sum), "confirm index past its length")
    `X224CRH_ASSERT_IMPL(a_ok_status, o_rsp.valid && o_rsp.byte_valid, o_rsp.status == ST_OK || o_rsp.status == ST_NEG_FAIL, "confirm beat with error status")
    `X224CRH_ASSERT_NEXT(a_idle_after_end, out_fire && emit_last && !r_pend_vld, !o_rsp.valid, "beat shown with no verdict queued")
    `X224CRH_ASSERT_NEXT(a_queue_filled, push, r_pend_vld, "final byte lost its verdict")

endmodule

// ===== tb/x224_connection_request_handler_core_test.sv =====
`timescale 1ns / 100ps

module x224_connection_request_handler_core_test;
    import x224crh_pkg::*;

    // Security modes the package leaves unnamed.
    localparam logic [1:0] SEC_NEGOTIATE = 2'd1;
    localparam logic [1:0] SEC_UNUSED    = 2'd3;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 8;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 40;

    // Register settings per random phase; every value of every register, extremes included.
    localparam logic [1:0] PHASE_SEC [RANDOM_PHASES] = '{SEC_RDP_ONLY, SEC_TLS_REQ, SEC_TLS_REQ,
        SEC_TLS_REQ, SEC_NEGOTIATE, SEC_UNUSED, SEC_RDP_ONLY, SEC_NEGOTIATE};
    localparam logic PHASE_VM  [RANDOM_PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    localparam logic PHASE_TLS [RANDOM_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

    // One beat of the confirm channel, as seen on o_rsp.
    typedef struct packed {
        logic [7:0] data;
        logic       byte_ok;
        logic [2:0] status;
        logic [3:0] proto;
        logic       eor;
    } t_confirm_beat;

    // Tracks the request parse, works out the confirm each final byte causes and
    // matches the beats on o_rsp against it in order.
    class confirm_scoreboard;
        logic [1:0]  sec_mode;
        logic        vm_mode;
        logic        tls_ready;

        int unsigned pos;
        t_phase      phase;
        int unsigned field_cnt;
        logic [7:0]  li;
        logic [7:0]  code;
        logic [3:0]  req_protos;
        logic [15:0] opt_len;
        logic        neg_seen;
        logic        after_cr;
        logic        rec_bad;
        logic [2:0]  err;

        t_confirm_beat beats_due[$];
        int unsigned   n_fail;
        int unsigned   n_checked;

        function new();
            sec_mode  = SEC_NEGOTIATE;
            vm_mode   = 1'b0;
            tls_ready = 1'b0;
            n_fail    = 0;
            n_checked = 0;
            clear_request();
        endfunction

        function void clear_request();
            pos        = 0;
            phase      = PH_HEADER;
            field_cnt  = 0;
            li         = 8'h00;
            code       = 8'h00;
            req_protos = 4'h0;
            opt_len    = 16'h0000;
            neg_seen   = 1'b0;
            after_cr   = 1'b0;
            rec_bad    = 1'b0;
            err        = ST_OK;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_SECURITY_MODE: sec_mode  = value;
                CFG_VM_CONNECT:    vm_mode   = value[0];
                CFG_TLS_READY:     tls_ready = value[0];
                default: ;
            endcase
        endfunction

        function void take_request_byte(logic [7:0] b, logic last);
            logic [2:0]    st;
            logic [3:0]    mask;
            logic [3:0]    proto;
            logic [1:0]    fail;
            logic [7:0]    cc [19];
            int            len;
            int            k;
            t_confirm_beat beat;

            case (phase)
                PH_HEADER: begin
                    if (pos == 0 && b != TPKT_VERSION) err = ST_BAD_HDR;
                    if (pos == 4) li = b;
                    if (pos == 5) code = b;
                    if (pos == 10) phase = PH_TYPE;
                end
                PH_TYPE: begin
                    if (b == OPT_NEG_REQ) begin
                        neg_seen  = 1'b1;
                        phase     = PH_NEGREQ;
                        field_cnt = 0;
                        rec_bad   = 1'b0;
                    end else if (b == OPT_CORR_INFO) begin
                        phase     = PH_CORR;
                        field_cnt = 0;
                    end else if (b == OPT_COOKIE) begin
                        phase    = PH_COOKIE;
                        after_cr = 1'b0;
                    end
                end
                PH_NEGREQ: begin
                    case (field_cnt)
                        0: begin
                            if ((b & NEG_FLAG_MASK) != b || (b[1] && !b[0])) rec_bad = 1'b1;
                        end
                        1: opt_len = {8'h00, b};
                        2: begin
                            opt_len[15:8] = b;
                            if (opt_len != 16'(NEG_REC_LEN)) rec_bad = 1'b1;
                        end
                        3: begin
                            if (b > MAX_PROTOCOLS) rec_bad = 1'b1;
                            else req_protos = b[3:0];
                        end
                        default: begin
                            if (b != 8'h00) rec_bad = 1'b1;
                        end
                    endcase
                    field_cnt++;
                    if (field_cnt >= NEG_REQ_BYTES) begin
                        if (rec_bad) begin
                            if (err == ST_OK) err = ST_BAD_NEG;
                            phase = PH_STOP;
                        end else begin
                            phase = PH_TYPE;
                        end
                    end
                end
                PH_CORR: begin
                    field_cnt++;
                    if (field_cnt >= CORR_BYTES) phase = PH_TYPE;
                end
                PH_COOKIE: begin
                    if (after_cr && b == CHAR_LF) begin
                        after_cr = 1'b0;
                        phase    = PH_TYPE;
                    end else begin
                        after_cr = (b == CHAR_CR);
                    end
                end
                default: ;
            endcase
            if (pos < POS_MAX) pos++;
            if (!last) return;

            // Header rules in priority order; 6 bytes reach the code, 11 end the fixed header.
            if (pos < 6 || err == ST_BAD_HDR || li == LI_INVALID) st = ST_BAD_HDR;
            else if (code == TPDU_DT) st = (pos < 7) ? ST_BAD_HDR : ST_NOT_CR;
            else if (pos < 11) st = ST_BAD_HDR;
            else if (code != TPDU_CR) st = ST_NOT_CR;
            else if (int'(li) != int'(pos) - 5) st = ST_LI_MISM;
            else if (err != ST_OK) st = err;
            else if (phase == PH_NEGREQ || phase == PH_CORR) st = ST_TRUNC;
            else st = ST_OK;

            if (st != ST_OK) begin
                beat.data    = 8'h00;
                beat.byte_ok = 1'b0;
                beat.status  = st;
                beat.proto   = PROTO_RDP;
                beat.eor     = 1'b1;
                beats_due.push_back(beat);
            end else begin
                mask = (sec_mode == SEC_RDP_ONLY) ? 4'b0000 : 4'b0001;
                if (vm_mode) mask |= 4'b1010;
                mask &= req_protos;
                proto = PROTO_RDP;
                fail  = FAIL_NONE;
                if (mask[3]) begin
                    proto = PROTO_HYB_EX;
                end else if (mask[1]) begin
                    proto = PROTO_HYBRID;
                end else if (mask[0]) begin
                    if (tls_ready || vm_mode) proto = PROTO_TLS;
                    else if (sec_mode == SEC_TLS_REQ) fail = FAIL_NO_CERT;
                end else if (sec_mode == SEC_TLS_REQ) begin
                    fail = FAIL_SSL_REQ;
                end

                len = neg_seen ? CC_LEN_LONG : CC_LEN_SHORT;
                cc = '{default: 8'h00};
                cc[0]  = TPKT_VERSION;
                cc[3]  = 8'(len);
                cc[4]  = 8'(len - 5);
                cc[5]  = TPDU_CC;
                cc[8]  = SRC_REF_HI;
                cc[9]  = SRC_REF_LO;
                cc[11] = (fail != FAIL_NONE) ? OPT_NEG_FAIL : OPT_NEG_RSP;
                cc[12] = (fail != FAIL_NONE) ? 8'h00 : (vm_mode ? RSP_FLAGS_VM : RSP_FLAGS);
                cc[13] = NEG_REC_LEN;
                cc[15] = (fail != FAIL_NONE) ? {6'd0, fail} : {4'd0, proto};
                for (k = 0; k < len; k++) begin
                    beat.data    = cc[k];
                    beat.byte_ok = 1'b1;
                    beat.status  = (fail != FAIL_NONE) ? ST_NEG_FAIL : ST_OK;
                    beat.proto   = proto;
                    beat.eor     = (k == len - 1);
                    beats_due.push_back(beat);
                end
            end
            clear_request();
        endfunction

        task report(string msg);
            if (n_fail < MAX_REPORTS) $display("MISMATCH: %s", msg);
            n_fail++;
        endtask

        task check_confirm_beat(t_confirm_beat got);
            t_confirm_beat want;
            n_checked++;
            if (beats_due.size() == 0) begin
                report($sformatf("beat %0d: response %02h arrived with nothing due",
                                 n_checked, got.data));
                return;
            end
            want = beats_due.pop_front();
            if (got.data !== want.data)
                report($sformatf("beat %0d: response_byte %02h, want %02h",
                                 n_checked, got.data, want.data));
            if (got.byte_ok !== want.byte_ok)
                report($sformatf("beat %0d: byte_valid %b, want %b",
                                 n_checked, got.byte_ok, want.byte_ok));
            if (got.status !== want.status)
                report($sformatf("beat %0d: status %0d, want %0d",
                                 n_checked, got.status, want.status));
            if (got.proto !== want.proto)
                report($sformatf("beat %0d: selected_protocol %0d, want %0d",
                                 n_checked, got.proto, want.proto));
            if (got.eor !== want.eor)
                report($sformatf("beat %0d: end_of_response %b, want %b",
                                 n_checked, got.eor, want.eor));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    x224crh_in_if  req_if ();
    x224crh_out_if rsp_if ();

    x224_connection_request_handler_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    confirm_scoreboard sb;
    logic [7:0]        pdu_bytes[$];   // request being built, sent front to back
    int                burst_left;
    int                items_sent;
    int                idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Request builders. Each request starts with a TPKT header and a CR
    // fixed header whose reference and class bytes carry random content.
    // ---------------------------------------------------------------------
    function automatic void begin_cr();
        pdu_bytes = {TPKT_VERSION, 8'($urandom), 8'h00, 8'h00, 8'h00, TPDU_CR};
        repeat (5) pdu_bytes.push_back(8'($urandom));
    endfunction

    // Fill in the TPKT length and an LI that matches the byte count.
    function automatic void close_cr();
        int n;
        n = pdu_bytes.size();
        pdu_bytes[2] = 8'(n >> 8);
        pdu_bytes[3] = 8'(n);
        pdu_bytes[4] = 8'(n - 5);
    endfunction

    function automatic void trim_to(int n);
        while (pdu_bytes.size() > n) void'(pdu_bytes.pop_back());
    endfunction

    // Negotiation request; tail lands on the first of the three bytes that must be zero.
    function automatic void add_neg_req(logic [7:0] flags, logic [7:0] protos,
                                        logic [15:0] rec_len, logic [7:0] tail);
        pdu_bytes = {pdu_bytes, OPT_NEG_REQ, flags, rec_len[7:0], rec_len[15:8], protos,
                     tail, 8'h00, 8'h00};
    endfunction

    function automatic void add_corr();
        pdu_bytes.push_back(OPT_CORR_INFO);
        repeat (CORR_BYTES) pdu_bytes.push_back(8'($urandom));
    endfunction

    function automatic void add_cookie(int n);
        pdu_bytes.push_back(OPT_COOKIE);
        repeat (n) pdu_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
        pdu_bytes.push_back(CHAR_CR);
        pdu_bytes.push_back(CHAR_LF);
    endfunction

    // ---------------------------------------------------------------------
    // Drivers. Inputs change on the falling edge; a beat counts at the
    // rising edge where valid and ready are both high.
    // ---------------------------------------------------------------------

    // Send the built request, rx_last on its final byte. The sender works in
    // bursts; at the end of each burst drop valid for a random pause.
    task automatic send_pdu();
        int k;
        for (k = 0; k < pdu_bytes.size(); k++) begin
            if (burst_left <= 0) begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
            end
            req_if.valid   <= 1'b1;
            req_if.rx_byte <= pdu_bytes[k];
            req_if.rx_last <= (k == pdu_bytes.size() - 1);
            @(posedge i_clk);
            while (!req_if.ready) @(posedge i_clk);
            @(negedge i_clk);
            burst_left--;
            items_sent++;
        end
    endtask

    // Hold the sender until every confirm beat due has come, then let the
    // block's pipeline run dry.
    task automatic settle();
        req_if.valid <= 1'b0;
        while (sb.beats_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write all three registers on consecutive cycles; wr_en stays high through
    // the run of writes and drops once afterwards.
    task automatic write_config(input logic [1:0] sec, input logic vm, input logic tls);
        logic [CFG_IDX_W-1:0]  idxs [3];
        logic [CFG_DATA_W-1:0] vals [3];
        int k;
        idxs = '{CFG_SECURITY_MODE, CFG_VM_CONNECT, CFG_TLS_READY};
        vals = '{sec, {1'b0, vm}, {1'b0, tls}};
        for (k = 0; k < 3; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idxs[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            sb.set_register(idxs[k], vals[k]);
            @(negedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // Receiver: stretches of always-ready, coin-flip, sparse and periodic
    // long stalls, so back-pressure can land on any beat of a confirm.
    initial begin
        int mode;
        int stretch;
        int period;
        int cnt;
        rsp_if.ready = 1'b0;
        forever begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(20, 120);
            period  = $urandom_range(1, 15);
            for (cnt = 0; cnt < stretch; cnt++) begin
                @(negedge i_clk);
                case (mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_if.ready <= ((cnt % (period + 1)) == period);
                endcase
            end
        end
    end

    // Monitor: feed accepted request bytes to the predictor, check confirm
    // beats, and end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        t_confirm_beat got;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                sb.take_request_byte(req_if.rx_byte, req_if.rx_last);
            if (rsp_if.valid && rsp_if.ready) begin
                got.data    = rsp_if.response_byte;
                got.byte_ok = rsp_if.byte_valid;
                got.status  = rsp_if.status;
                got.proto   = rsp_if.selected_protocol;
                got.eor     = rsp_if.end_of_response;
                sb.check_confirm_beat(got);
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] flags_ok [6];
        int kind;
        int sel;
        int n;
        int p;
        int phase_start;

        flags_ok = '{8'h00, 8'h01, 8'h03, 8'h08, 8'h09, NEG_FLAG_MASK};
        sb = new();
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = CFG_SECURITY_MODE;
        i_cfg_wdata    = '0;
        req_if.valid   = 1'b0;
        req_if.rx_byte = 8'h00;
        req_if.rx_last = 1'b0;
        burst_left     = 0;
        items_sent     = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // -------- Directed requests, under the reset register values --------

        // Bare request, no options: short confirm.
        begin_cr(); close_cr(); send_pdu();
        // Negotiation asking for every protocol with no flags.
        begin_cr(); add_neg_req(8'h00, MAX_PROTOCOLS, 16'(NEG_REC_LEN), 8'h00);
        close_cr(); send_pdu();
        // Cookie, then negotiation with all legal flags and no protocols.
        begin_cr(); add_cookie(6); add_neg_req(NEG_FLAG_MASK, 8'h00, 16'(NEG_REC_LEN), 8'h00);
        close_cr(); send_pdu();
        // Correlation record, negotiation, then ignored extreme bytes.
        begin_cr(); add_corr(); add_neg_req(8'h09, 8'h08, 16'(NEG_REC_LEN), 8'h00);
        pdu_bytes = {pdu_bytes, 8'hFF, 8'h00};
        close_cr(); send_pdu();
        // Flag outside the legal set.
        begin_cr(); add_neg_req(8'h04, 8'h01, 16'(NEG_REC_LEN), 8'h00); close_cr(); send_pdu();
        // Flag 0x02 without 0x01.
        begin_cr(); add_neg_req(8'h02, 8'h01, 16'(NEG_REC_LEN), 8'h00); close_cr(); send_pdu();
        // Record length wrong in the low byte, then in the high byte.
        begin_cr(); add_neg_req(8'h01, 8'h01, 16'h0009, 8'h00); close_cr(); send_pdu();
        begin_cr(); add_neg_req(8'h01, 8'h01, 16'h0108, 8'h00); close_cr(); send_pdu();
        // Protocols above the limit, then all ones.
        begin_cr(); add_neg_req(8'h01, 8'h0C, 16'(NEG_REC_LEN), 8'h00); close_cr(); send_pdu();
        begin_cr(); add_neg_req(8'h01, 8'hFF, 16'(NEG_REC_LEN), 8'h00); close_cr(); send_pdu();
        // Non-zero reserved byte; a good record after the fault is ignored.
        begin_cr(); add_neg_req(8'h01, 8'h01, 16'(NEG_REC_LEN), 8'h80);
        add_neg_req(8'h01, 8'h02, 16'(NEG_REC_LEN), 8'h00);
        close_cr(); send_pdu();
        // Cookie cut short after CR: no error.
        begin_cr(); pdu_bytes = {pdu_bytes, OPT_COOKIE, 8'h61, CHAR_CR}; close_cr(); send_pdu();
        // Request ending inside a negotiation record, then inside a correlation record.
        begin_cr(); pdu_bytes = {pdu_bytes, OPT_NEG_REQ, 8'h01}; close_cr(); send_pdu();
        begin_cr(); pdu_bytes.push_back(OPT_CORR_INFO);
        repeat (10) pdu_bytes.push_back(8'($urandom));
        close_cr(); send_pdu();
        // Wrong TPKT version.
        begin_cr(); close_cr(); pdu_bytes[0] = 8'h02; send_pdu();
        // LI of 255.
        begin_cr(); close_cr(); pdu_bytes[4] = LI_INVALID; send_pdu();
        // One-byte and five-byte requests.
        pdu_bytes = {TPKT_VERSION}; send_pdu();
        begin_cr(); trim_to(5); send_pdu();
        // Data TPDU, six bytes then a full fixed header.
        begin_cr(); pdu_bytes[5] = TPDU_DT; trim_to(6); send_pdu();
        begin_cr(); close_cr(); pdu_bytes[5] = TPDU_DT; send_pdu();
        // Code other than CR.
        begin_cr(); close_cr(); pdu_bytes[5] = TPDU_CC; send_pdu();
        // Fixed header cut at eight bytes.
        begin_cr(); trim_to(8); close_cr(); send_pdu();
        // LI one above the byte count.
        begin_cr(); close_cr(); pdu_bytes[4] = pdu_bytes[4] + 8'd1; send_pdu();

        // -------- Random requests, one batch per register setting --------
        for (p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            write_config(PHASE_SEC[p], PHASE_VM[p], PHASE_TLS[p]);
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                kind = $urandom_range(0, 99);
                if (kind < 10) begin
                    // Noise: random bytes, sometimes behind a good version byte.
                    pdu_bytes.delete();
                    if ($urandom_range(0, 1)) pdu_bytes.push_back(TPKT_VERSION);
                    repeat ($urandom_range(1, 24)) pdu_bytes.push_back(8'($urandom));
                end else begin
                    // Request with a valid header and random options, negotiation records half the time.
                    begin_cr();
                    repeat ($urandom_range(0, 3)) begin
                        sel = $urandom_range(0, 9);
                        if (sel < 5)
                            add_neg_req(
                                ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                            : flags_ok[$urandom_range(0, 5)],
                                ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                            : 8'($urandom_range(0, 11)),
                                ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(NEG_REC_LEN),
                                ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'h00);
                        else if (sel < 7)
                            add_cookie($urandom_range(0, 12));
                        else if (sel == 7)
                            add_corr();
                        else
                            pdu_bytes.push_back(8'($urandom));
                    end
                    close_cr();
                    if (kind < 20) begin
                        // Cut short; half the time fix LI so the header still passes.
                        n = $urandom_range(1, pdu_bytes.size() - 1);
                        trim_to(n);
                        if (n > 4 && $urandom_range(0, 1)) pdu_bytes[4] = 8'(n - 5);
                    end else if (kind < 28) begin
                        // Corrupt one byte anywhere.
                        pdu_bytes[$urandom_range(0, pdu_bytes.size() - 1)] = 8'($urandom);
                    end
                end
                send_pdu();
                // Now and then hold the sender until the confirm has drained.
                if ($urandom_range(0, 9) == 0) settle();
            end
        end

        settle();
        if (sb.n_fail == 0 && sb.beats_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
